/* sv/sha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_ROUND,
        ST_PAD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_byte;
        logic start_rounds;
        logic round_step;
        logic finish_block;
        logic pad_begin;
        logic pad_second;
        logic clear_msg;
        logic emit_next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       block_full;
        logic       rounds_done;
        logic       need_extra;
        logic [2:0] emit_idx;
    } t_status;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [63:0] BlockBits  = 64'd512;
    localparam logic [6:0]  LenOffset  = 7'd56;

endpackage
`default_nettype wire

/* sv/sha_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_fire,
    input  wire logic            i_has_byte,
    input  wire logic            i_end_msg,
    input  wire logic            i_out_ready,
    input  wire sha_pkg::t_status i_status,
    output sha_pkg::t_cmd        o_cmd,
    output logic                 o_in_ready,
    output logic                 o_out_valid
);
    import sha_pkg::*;

    t_state r_state, n_state;
    logic   r_final, n_final;   // rounds belong to the final block
    logic   r_extra, n_extra;   // a second padded block is still owed
    logic   r_end, n_end;       // end of message was seen with this full block

    // next state
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_extra = r_extra;
        n_end   = r_end;
        unique case (r_state)
            ST_FILL: begin
                if (i_in_fire) begin
                    if (i_has_byte && i_status.block_full) begin
                        n_state = ST_ROUND;
                        n_final = 1'b0;
                        n_end   = i_end_msg;
                    end else if (i_end_msg) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_state = ST_ROUND;
                n_final = !i_status.need_extra;
                n_extra = i_status.need_extra;
            end
            ST_ROUND: begin
                if (i_status.rounds_done) begin
                    if (r_end) begin
                        n_state = ST_PAD;
                        n_end   = 1'b0;
                    end else if (r_extra) begin
                        n_state = ST_ROUND;
                        n_extra = 1'b0;
                        n_final = 1'b1;
                    end else if (r_final) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_EMIT: begin
                if (i_out_ready && i_status.emit_idx == 3'd7) begin
                    n_state = ST_FILL;
                    n_final = 1'b0;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                o_in_ready           = 1'b1;
                o_cmd.load_byte      = i_in_fire && i_has_byte;
                o_cmd.start_rounds   = i_in_fire && i_has_byte && i_status.block_full;
            end
            ST_PAD: begin
                o_cmd.pad_begin    = 1'b1;
                o_cmd.start_rounds = 1'b1;
            end
            ST_ROUND: begin
                o_cmd.round_step   = !i_status.rounds_done;
                o_cmd.finish_block = i_status.rounds_done;
                o_cmd.pad_second   = i_status.rounds_done && r_extra;
                o_cmd.start_rounds = i_status.rounds_done && r_extra;
            end
            ST_EMIT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_next = i_out_ready;
                o_cmd.clear_msg = i_out_ready && i_status.emit_idx == 3'd7;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_final <= 1'b0;
            r_extra <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_extra <= n_extra;
            r_end   <= n_end;
        end
    end
endmodule
`default_nettype wire

/* sv/sha_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sha_pkg::t_cmd   i_cmd,
    input  wire logic [7:0]      i_byte,
    output sha_pkg::t_status     o_status,
    output logic [31:0]          o_word
);
    import sha_pkg::*;

    logic [31:0] r_chain [8];
    logic [31:0] r_work  [8];
    logic [31:0] r_w     [16];   // message schedule window
    logic [31:0] r_msg   [16];   // block buffer, big-endian bytes per word
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [6:0]  r_round;        // 64 means idle / done
    logic [2:0]  r_emit;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    // byte block as loaded into the schedule, with padding applied
    logic [7:0]  pad_blk [64];
    logic [7:0]  pad2_blk [64];
    logic [63:0] len_now;
    assign len_now = r_bits + {55'd0, r_fill, 3'd0};

    always_comb begin
        for (int wi = 0; wi < 16; wi++) begin
            for (int bi = 0; bi < 4; bi++) begin
                if (4*wi + bi < r_fill)       pad_blk[4*wi + bi] = r_msg[wi][8*(3 - bi) +: 8];
                else if (4*wi + bi == r_fill) pad_blk[4*wi + bi] = PadByte;
                else                          pad_blk[4*wi + bi] = 8'h00;
                pad2_blk[4*wi + bi] = 8'h00;
            end
        end
        if (r_fill < 6'd56) begin
            for (int i = 0; i < 8; i++) pad_blk[63 - i] = len_now[8*i +: 8];
        end
        for (int i = 0; i < 8; i++) pad2_blk[63 - i] = r_len[8*i +: 8];
    end

    // one round
    logic [31:0] s1, ch, t1, s0, maj, t2, wn, x, y;
    always_comb begin
        s1  = rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25);
        ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        t1  = r_work[7] + s1 + ch + RoundK[r_round[5:0]] + r_w[0];
        s0  = rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22);
        maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
        t2  = s0 + maj;
        x   = r_w[1];
        y   = r_w[14];
        wn  = r_w[0] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + r_w[9]
            + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    end

    assign o_status.block_full  = (r_fill == 6'd63);
    assign o_status.rounds_done = r_round[6];
    assign o_status.need_extra  = (r_fill >= 6'd56);
    assign o_status.emit_idx    = r_emit;
    assign o_word               = r_chain[r_emit];

    always_ff @(posedge i_clk) begin
        // block byte store, one byte lane of one word
        if (i_cmd.load_byte) r_msg[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_byte;
        // schedule and working set
        if (i_cmd.start_rounds) begin
            for (int i = 0; i < 16; i++) begin
                if (i_cmd.pad_second)
                    r_w[i] <= {pad2_blk[4*i], pad2_blk[4*i+1], pad2_blk[4*i+2], pad2_blk[4*i+3]};
                else if (i_cmd.pad_begin)
                    r_w[i] <= {pad_blk[4*i], pad_blk[4*i+1], pad_blk[4*i+2], pad_blk[4*i+3]};
                else if (i_cmd.load_byte && i == 15)
                    r_w[i] <= {r_msg[15][31:8], i_byte};
                else
                    r_w[i] <= r_msg[i];
            end
            if (i_cmd.pad_second) begin
                for (int i = 0; i < 8; i++) r_work[i] <= r_chain[i] + r_work[i];
            end else begin
                for (int i = 0; i < 8; i++) r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.round_step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + t2;
        end
        if (i_cmd.pad_begin) r_len <= len_now;

        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= InitHash[i];
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= 7'd64;
            r_emit  <= '0;
        end else begin
            if (i_cmd.load_byte) r_fill <= r_fill + 6'd1;
            if (i_cmd.start_rounds)    r_round <= '0;
            else if (i_cmd.round_step) r_round <= r_round + 7'd1;
            if (i_cmd.start_rounds && !i_cmd.pad_begin && !i_cmd.pad_second)
                r_bits <= r_bits + BlockBits;
            if (i_cmd.pad_begin) r_fill <= '0;
            // chain update at the end of each block
            if (i_cmd.finish_block && !i_cmd.pad_second)
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_work[i];
            if (i_cmd.pad_second)
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_work[i];
            if (i_cmd.emit_next) r_emit <= r_emit + 3'd1;
            if (i_cmd.clear_msg) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= InitHash[i];
                r_bits <= '0;
                r_fill <= '0;
                r_emit <= '0;
            end
        end
    end
endmodule
`default_nettype wire

/* sv/sha256_stream_hasher.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | handshake         | payload
// s_axis    | in  | tvalid / tready   | tdata = data_byte, tuser = has_byte, tlast = end_of_message
// m_axis    | out | tvalid / tready   | tdata = digest_word, tuser = word_index, tlast = last_word
//
// a byte is taken each cycle while a block fills; the 64th byte holds input
// off while the 64 rounds run, one a cycle, and then the chain update.
// end of message costs a pad state plus a padded block of rounds, and
// another such block if 56 or more bytes pend, then eight digest beats;
// a stalled output holds the word.
// synchronous active-low reset loads the initial hash and empties the block.
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast
);
    import sha_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // control
    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_has_byte  (s_axis_tuser),
        .i_end_msg   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    // hashing datapath
    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (s_axis_tdata),
        .o_status (status),
        .o_word   (m_axis_tdata)
    );

    assign m_axis_tuser = status.emit_idx;
    assign m_axis_tlast = (status.emit_idx == 3'd7);

    // no input is taken while digest beats are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output both open");
    // word index advances on each output beat that is not the last
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tuser == $past(m_axis_tuser) + 3'd1)) else $error("word index skipped");
    // after the last word the block is ready again
    a_back_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after digest");
endmodule
`default_nettype wire
